FILE: sv/dwt53_pkg.sv
// shared types and constants of the 5/3 forward line transform
package dwt53_pkg;

   localparam int SampleW = 16;
   localparam int CoefW   = 17;

   localparam logic RegLineStartOdd = 1'b0;

   typedef logic signed [SampleW-1:0] sample_type;
   typedef logic signed [CoefW-1:0]   coef_type;

   typedef struct packed {
      sample_type sample_value;
      logic       line_end;
   } req_type;

   typedef struct packed {
      coef_type coefficient;
      logic     is_high_band;
      logic     line_done;
   } rsp_type;

   typedef struct packed {
      sample_type odd_s;
      sample_type left_s;
      sample_type right_s;
      sample_type even_s;
      sample_type tail_s;
      logic       first;
      logic       emit_low;
      logic       emit_high;
      logic       emit_tail;
      logic       high_done;
   } job_type;

endpackage

FILE: sv/dwt53_front.sv
// front end: tracks line position and turns samples into lifting jobs
module dwt53_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  dwt53_pkg::req_type req_data,
   input  logic               start_odd,
   output logic               job_push,
   output dwt53_pkg::job_type job_data
);
   import dwt53_pkg::*;

   localparam int EffBits = (SAMPLE_BITS < SampleW) ? SAMPLE_BITS : SampleW;

   typedef enum logic [1:0] {
      PH_EMPTY,
      PH_EVEN,
      PH_PAIR,
      PH_ODD_FIRST
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic                       first_ff, first_in;
   logic signed [EffBits-1:0]  held_even_ff, held_even_in;
   logic signed [EffBits-1:0]  held_odd_ff, held_odd_in;
   logic signed [EffBits-1:0]  v_n;
   sample_type                 v;
   sample_type                 even_x;
   sample_type                 odd_x;
   logic                       last;

   assign v_n    = req_data.sample_value[EffBits-1:0];
   assign v      = sample_type'(v_n);
   assign even_x = sample_type'(held_even_ff);
   assign odd_x  = sample_type'(held_odd_ff);
   assign last   = req_data.line_end;

   always_comb begin
      phase_in     = phase_ff;
      first_in     = first_ff;
      held_even_in = held_even_ff;
      held_odd_in  = held_odd_ff;
      job_push     = 1'b0;
      job_data     = '0;
      job_data.tail_s = v;
      job_data.first  = first_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_EMPTY: begin
               if (last) begin
                  job_push           = 1'b1;
                  job_data.emit_tail = 1'b1;
               end else if (start_odd) begin
                  held_odd_in = v_n;
                  phase_in    = PH_ODD_FIRST;
               end else begin
                  held_even_in = v_n;
                  phase_in     = PH_EVEN;
               end
            end
            PH_EVEN: begin
               if (last) begin
                  job_push           = 1'b1;
                  job_data.odd_s     = v;
                  job_data.left_s    = even_x;
                  job_data.right_s   = even_x;
                  job_data.even_s    = even_x;
                  job_data.emit_low  = 1'b1;
                  job_data.emit_high = 1'b1;
                  job_data.high_done = 1'b1;
                  phase_in           = PH_EMPTY;
                  first_in           = 1'b1;
               end else begin
                  held_odd_in = v_n;
                  phase_in    = PH_PAIR;
               end
            end
            PH_PAIR: begin
               job_push           = 1'b1;
               job_data.odd_s     = odd_x;
               job_data.left_s    = even_x;
               job_data.right_s   = v;
               job_data.even_s    = even_x;
               job_data.emit_low  = 1'b1;
               job_data.emit_high = 1'b1;
               job_data.emit_tail = last;
               if (last) begin
                  phase_in = PH_EMPTY;
                  first_in = 1'b1;
               end else begin
                  held_even_in = v_n;
                  first_in     = 1'b0;
                  phase_in     = PH_EVEN;
               end
            end
            PH_ODD_FIRST: begin
               job_push           = 1'b1;
               job_data.odd_s     = odd_x;
               job_data.left_s    = v;
               job_data.right_s   = v;
               job_data.emit_high = 1'b1;
               job_data.emit_tail = last;
               if (last) begin
                  phase_in = PH_EMPTY;
                  first_in = 1'b1;
               end else begin
                  held_even_in = v_n;
                  first_in     = 1'b0;
                  phase_in     = PH_EVEN;
               end
            end
            default: begin
               phase_in = PH_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_EMPTY;
         first_ff     <= 1'b1;
         held_even_ff <= '0;
         held_odd_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         held_even_ff <= held_even_in;
         held_odd_ff  <= held_odd_in;
      end
   end

endmodule

FILE: sv/dwt53_queue.sv
// job queue between the front end and the lifting back end
module dwt53_queue #(
   parameter int Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dwt53_pkg::job_type push_data,
   output logic               full,
   input  logic               pop,
   output dwt53_pkg::job_type pop_data,
   output logic               empty
);
   import dwt53_pkg::*;

   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type           mem_ff [Depth];
   logic [IdxW-1:0]   wr_ff, wr_in;
   logic [IdxW-1:0]   rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (cnt_ff == CntW'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == IdxW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == IdxW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/dwt53_back.sv
// back end: high step, low step and result buffer
module dwt53_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  dwt53_pkg::job_type job_data,
   output logic               job_pop,
   output dwt53_pkg::rsp_type rsp_data,
   output logic               empty,
   input  logic               pop
);
   import dwt53_pkg::*;

   logic              b1_valid_ff, b1_valid_in;
   job_type           b1_job_ff;
   logic              b2_valid_ff, b2_valid_in;
   job_type           b2_job_ff;
   coef_type          d_ff;
   coef_type          prev_ff;
   logic [2:0]        mask_ff, mask_in;

   rsp_type           of_mem_ff [2];
   logic              of_wr_ff;
   logic              of_rd_ff;
   logic [1:0]        of_cnt_ff, of_cnt_in;

   logic signed [17:0] pair_sum;
   logic signed [17:0] d_wide;
   coef_type           d_in;
   coef_type           dl;
   logic signed [18:0] low_sum;
   logic signed [18:0] s_first_w;
   logic signed [18:0] tail_sum;
   logic signed [18:0] s_tail_w;
   logic [2:0]         mask_next;
   logic               of_room;
   logic               emit;
   logic               b2_done;
   logic               b2_free;
   logic               b1_move;
   logic               b1_free;
   logic               of_pop;
   rsp_type            pick;

   // high step from the staged job
   assign pair_sum = 18'(b1_job_ff.left_s) + 18'(b1_job_ff.right_s);
   assign d_wide   = 18'(b1_job_ff.odd_s) - (pair_sum >>> 1);
   assign d_in     = d_wide[CoefW-1:0];

   // low steps from the registered high coefficient
   assign dl        = b2_job_ff.first ? d_ff : prev_ff;
   assign low_sum   = 19'(dl) + 19'(d_ff) + 19'sd2;
   assign s_first_w = 19'(b2_job_ff.even_s) + (low_sum >>> 2);
   assign tail_sum  = 19'(d_ff) + 19'(d_ff) + 19'sd2;
   assign s_tail_w  = 19'(b2_job_ff.tail_s) + (tail_sum >>> 2);

   assign of_room = (of_cnt_ff != 2'd2);
   assign emit    = b2_valid_ff && of_room;
   assign of_pop  = pop && !empty;

   always_comb begin
      pick      = '0;
      mask_next = mask_ff;
      if (mask_ff[0]) begin
         pick.coefficient  = s_first_w[CoefW-1:0];
         pick.is_high_band = 1'b0;
         pick.line_done    = 1'b0;
         mask_next         = {mask_ff[2:1], 1'b0};
      end else if (mask_ff[1]) begin
         pick.coefficient  = d_ff;
         pick.is_high_band = 1'b1;
         pick.line_done    = b2_job_ff.high_done;
         mask_next         = {mask_ff[2], 2'b00};
      end else begin
         pick.coefficient  = s_tail_w[CoefW-1:0];
         pick.is_high_band = 1'b0;
         pick.line_done    = 1'b1;
         mask_next         = 3'b000;
      end
   end

   assign b2_done = emit && (mask_next == 3'b000);
   assign b2_free = !b2_valid_ff || b2_done;
   assign b1_move = b1_valid_ff && b2_free;
   assign b1_free = !b1_valid_ff || b1_move;
   assign job_pop = job_valid && b1_free;

   always_comb begin
      b1_valid_in = b1_valid_ff;
      if (b1_free) begin
         b1_valid_in = job_valid;
      end
      b2_valid_in = b2_valid_ff;
      mask_in     = mask_ff;
      if (b2_free) begin
         b2_valid_in = b1_valid_ff;
         mask_in     = {b1_job_ff.emit_tail, b1_job_ff.emit_high, b1_job_ff.emit_low};
      end else if (emit) begin
         mask_in = mask_next;
      end
      case ({emit, of_pop})
         2'b10:   of_cnt_in = of_cnt_ff + 1'b1;
         2'b01:   of_cnt_in = of_cnt_ff - 1'b1;
         default: of_cnt_in = of_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         mask_ff     <= 3'b000;
         prev_ff     <= '0;
         of_wr_ff    <= 1'b0;
         of_rd_ff    <= 1'b0;
         of_cnt_ff   <= 2'd0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
         mask_ff     <= mask_in;
         of_cnt_ff   <= of_cnt_in;
         if (b2_done) begin
            prev_ff <= d_ff;
         end
         if (emit) begin
            of_wr_ff <= !of_wr_ff;
         end
         if (of_pop) begin
            of_rd_ff <= !of_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         b1_job_ff <= job_data;
      end
      if (b1_move) begin
         b2_job_ff <= b1_job_ff;
         d_ff      <= d_in;
      end
      if (emit) begin
         of_mem_ff[of_wr_ff] <= pick;
      end
   end

   assign empty    = (of_cnt_ff == 2'd0);
   assign rsp_data = of_mem_ff[of_rd_ff];

endmodule

FILE: sv/dwt53_forward_line.sv
// top level of the streaming forward 5/3 lifting line transform
//
// requests: push a sample with its line-end mark while full is low; one
// sample can be taken every cycle. results: while empty is low the oldest
// coefficient is on rsp_data and pop takes it, one per cycle.
// a sample yields zero to three coefficients; over a line their count
// equals the sample count, so one result per cycle keeps up with the input.
// path: with the back end idle, the first coefficient of a request goes
// through the job queue, the high-step and low-step stages and the result
// buffer to rsp_data; its others follow one per cycle while pop keeps up.
// the job queue of JOB_DEPTH entries absorbs the three-result bursts at a
// line end; full rises only when the queue holds JOB_DEPTH jobs.
// when pop stays low, the two-entry result buffer fills, the back end
// holds, the job queue fills and full goes high; nothing is lost.
// register 0 (line_start_odd, byte address 0) is read at each line start.
// reset clears line position, queues and line_start_odd; no clearing pass.
module dwt53_forward_line #(
   parameter int SAMPLE_BITS = 16,
   parameter int JOB_DEPTH   = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  dwt53_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output dwt53_pkg::rsp_type rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import dwt53_pkg::*;

   logic     start_odd_ff;
   logic     csr_write;
   logic     accept;
   logic     jq_push;
   job_type  jq_push_data;
   logic     jq_full;
   logic     jq_pop;
   job_type  jq_pop_data;
   logic     jq_empty;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = {31'b0, (paddr[2] == RegLineStartOdd) ? start_odd_ff : 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_odd_ff <= 1'b0;
      end else if (csr_write && (paddr[2] == RegLineStartOdd)) begin
         start_odd_ff <= pwdata[0];
      end
   end

   assign full   = jq_full;
   assign accept = push && !jq_full;

   dwt53_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .start_odd (start_odd_ff),
      .job_push  (jq_push),
      .job_data  (jq_push_data)
   );

   dwt53_queue #(
      .Depth (JOB_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (jq_push),
      .push_data (jq_push_data),
      .full      (jq_full),
      .pop       (jq_pop),
      .pop_data  (jq_pop_data),
      .empty     (jq_empty)
   );

   dwt53_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!jq_empty),
      .job_data  (jq_pop_data),
      .job_pop   (jq_pop),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .pop       (pop)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      jq_push |-> !jq_full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      jq_pop |-> !jq_empty)
      else $error("job taken from an empty queue");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> empty)
      else $error("result present right after reset");

endmodule
